// ===== src/kcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcd_pkg: shared types and codes for the capability descriptor decoder
// Result word layout, kind and status codes, mapping types and defaults.
// ----------------------------------------------------------------------------
package kcd_pkg;

    localparam int MAX_MAPPINGS_DEF     = 8;
    localparam int DESCRIPTOR_COUNT_DEF = 28;

    localparam int DESC_W   = 32;
    localparam int POS_W    = 6;
    localparam int MCOUNT_W = 7;
    localparam int PAGE_W   = 20;

    typedef enum logic [2:0] {
        KIND_PADDING = 3'd0,
        KIND_SYSCALL = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_HANDLES = 3'd3,
        KIND_FLAGS   = 3'd4,
        KIND_MAPPING = 3'd5,
        KIND_RANGE   = 3'd6,
        KIND_SKIPPED = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_CORRUPT     = 2'd2,
        ST_LIMIT       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MAP_STATIC_RW = 2'd0,
        MAP_STATIC_RO = 2'd1,
        MAP_IO_RW     = 2'd2,
        MAP_IO_RO     = 2'd3
    } map_type_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [5:0]  slot;
        logic [23:0] value;
        logic [19:0] map_start;
        logic [20:0] map_end;
        map_type_t   map_type;
        logic        block_done;
    } result_t;

endpackage
`default_nettype wire

// ===== src/kcd_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcd channels: valid/ready interfaces for descriptor and result words
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface kcd_desc_if;
    logic        valid;
    logic        ready;
    logic [31:0] descriptor;

    modport source (output valid, output descriptor, input ready);
    modport sink   (input valid, input descriptor, output ready);
endinterface

interface kcd_result_if;
    logic             valid;
    logic             ready;
    kcd_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/kernel_capability_descriptor_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kernel_capability_descriptor_decoder: capability descriptor block decoder
// Classifies each 32-bit descriptor word of a block and reports one result.
// ----------------------------------------------------------------------------
// Usage:
//   desc  - sink channel, one 32-bit descriptor word per handshake. A block
//           is DESCRIPTOR_COUNT words; block boundaries are counted here.
//   res   - source channel, exactly one result word per descriptor word.
//   Results are registered: a result loads as its descriptor is accepted.
//   Throughput: one word per cycle unless res stalls. The decode is a single
//   pass of prefix compares against the block state, between input port and
//   result register, so a new word can enter on every clock without a stall.
//   desc.ready is high whenever the result register is empty or being
//   drained in the same cycle; a stalled receiver holds the result and
//   back-pressures the input after exactly one word is stored.
//   Reset clears the block position, mapping count, pending range and the
//   sticky error, and empties the result register. The block state is
//   cleared again after the last word of every block.
//   After any error, the rest of the block reports kind skipped with the
//   stored error status.
// ----------------------------------------------------------------------------
module kernel_capability_descriptor_decoder #(
    parameter int MAX_MAPPINGS     = kcd_pkg::MAX_MAPPINGS_DEF,
    parameter int DESCRIPTOR_COUNT = kcd_pkg::DESCRIPTOR_COUNT_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    kcd_desc_if.sink     desc,
    kcd_result_if.source res
);
    import kcd_pkg::*;

    localparam logic [POS_W-1:0]    LAST_POS = POS_W'(DESCRIPTOR_COUNT - 1);
    localparam logic [MCOUNT_W-1:0] MAP_LIM  = MCOUNT_W'(MAX_MAPPINGS);

    // Block state
    logic [POS_W-1:0]    position_reg, position_next;
    logic [MCOUNT_W-1:0] mapping_count_reg, mapping_count_next;
    logic                range_pending_reg, range_pending_next;
    logic [PAGE_W-1:0]   pending_start_reg, pending_start_next;
    logic                pending_writable_reg, pending_writable_next;
    status_t             error_status_reg, error_status_next;

    // Result register
    logic    res_valid_reg;
    result_t res_data_reg, res_data_next;

    logic              accept;
    logic              last;
    logic              at_limit;
    logic [31:0]       d;
    logic [PAGE_W-1:0] page;

    // Take a word whenever the result slot is free or draining
    assign desc.ready = !res_valid_reg || res.ready;
    assign accept     = desc.valid && desc.ready;
    assign res.valid  = res_valid_reg;
    assign res.data   = res_data_reg;

    assign d        = desc.descriptor;
    assign page     = d[PAGE_W-1:0];
    assign last     = position_reg >= LAST_POS;
    assign at_limit = mapping_count_reg >= MAP_LIM;

    always_comb
    begin
        position_next         = position_reg;
        mapping_count_next    = mapping_count_reg;
        range_pending_next    = range_pending_reg;
        pending_start_next    = pending_start_reg;
        pending_writable_next = pending_writable_reg;
        error_status_next     = error_status_reg;
        res_data_next         = '0;

        if (error_status_reg != ST_OK)
        begin
            // Skip the rest of the block
            res_data_next.kind   = KIND_SKIPPED;
            res_data_next.status = error_status_reg;
        end
        else if (range_pending_reg)
        begin
            // Second word of a two-word range
            range_pending_next = 1'b0;
            if ((d & 32'hFFE0_0000) != 32'hFF80_0000)
            begin
                res_data_next.kind   = KIND_SKIPPED;
                res_data_next.status = ST_CORRUPT;
                error_status_next    = ST_CORRUPT;
            end
            else
            begin
                res_data_next.kind      = KIND_MAPPING;
                res_data_next.slot      = mapping_count_reg[5:0];
                res_data_next.map_start = pending_start_reg;
                res_data_next.map_end   = {1'b0, page};
                if (d[20])
                    res_data_next.map_type = pending_writable_reg ? MAP_STATIC_RW
                                                                  : MAP_STATIC_RO;
                else
                    res_data_next.map_type = pending_writable_reg ? MAP_IO_RW
                                                                  : MAP_IO_RO;
                mapping_count_next = mapping_count_reg + MCOUNT_W'(1);
            end
        end
        else if ((d & 32'hF000_0000) == 32'hE000_0000)
        begin
            // Interrupt descriptor
            res_data_next.kind   = KIND_SKIPPED;
            res_data_next.status = ST_UNSUPPORTED;
            error_status_next    = ST_UNSUPPORTED;
        end
        else if ((d & 32'hF800_0000) == 32'hF000_0000)
        begin
            res_data_next.kind  = KIND_SYSCALL;
            res_data_next.slot  = {3'b000, d[26:24]};
            res_data_next.value = d[23:0];
        end
        else if ((d & 32'hFE00_0000) == 32'hFC00_0000)
        begin
            res_data_next.kind  = KIND_RELEASE;
            res_data_next.value = {8'h00, d[15:0]};
        end
        else if ((d & 32'hFF00_0000) == 32'hFE00_0000)
        begin
            res_data_next.kind  = KIND_HANDLES;
            res_data_next.value = {14'h0000, d[9:0]};
        end
        else if ((d & 32'hFF80_0000) == 32'hFF00_0000)
        begin
            res_data_next.kind  = KIND_FLAGS;
            res_data_next.value = {8'h00, d[15:0]};
        end
        else if ((d & 32'hFFE0_0000) == 32'hFF80_0000)
        begin
            // First word of a range: limit first, then cut off at block end
            if (at_limit)
            begin
                res_data_next.kind   = KIND_SKIPPED;
                res_data_next.status = ST_LIMIT;
                error_status_next    = ST_LIMIT;
            end
            else if (last)
            begin
                res_data_next.kind   = KIND_SKIPPED;
                res_data_next.status = ST_CORRUPT;
                error_status_next    = ST_CORRUPT;
            end
            else
            begin
                range_pending_next      = 1'b1;
                pending_start_next      = page;
                pending_writable_next   = d[20];
                res_data_next.kind      = KIND_RANGE;
                res_data_next.slot      = mapping_count_reg[5:0];
                res_data_next.map_start = page;
            end
        end
        else if ((d & 32'hFFF0_0000) == 32'hFFE0_0000)
        begin
            // Single io page
            if (at_limit)
            begin
                res_data_next.kind   = KIND_SKIPPED;
                res_data_next.status = ST_LIMIT;
                error_status_next    = ST_LIMIT;
            end
            else
            begin
                res_data_next.kind      = KIND_MAPPING;
                res_data_next.slot      = mapping_count_reg[5:0];
                res_data_next.map_start = page;
                res_data_next.map_end   = {1'b0, page} + 21'd1;
                res_data_next.map_type  = d[20] ? MAP_IO_RW : MAP_IO_RO;
                mapping_count_next      = mapping_count_reg + MCOUNT_W'(1);
            end
        end
        else if (d == 32'hFFFF_FFFF)
        begin
            res_data_next.kind = KIND_PADDING;
        end
        else
        begin
            // Unknown prefix
            res_data_next.kind   = KIND_SKIPPED;
            res_data_next.status = ST_CORRUPT;
            error_status_next    = ST_CORRUPT;
        end

        if (last)
        begin
            // Close the block: drop all state
            res_data_next.block_done = 1'b1;
            position_next            = '0;
            mapping_count_next       = '0;
            range_pending_next       = 1'b0;
            pending_start_next       = '0;
            pending_writable_next    = 1'b0;
            error_status_next        = ST_OK;
        end
        else
        begin
            position_next = position_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg         <= '0;
            mapping_count_reg    <= '0;
            range_pending_reg    <= 1'b0;
            pending_start_reg    <= '0;
            pending_writable_reg <= 1'b0;
            error_status_reg     <= ST_OK;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                position_reg         <= position_next;
                mapping_count_reg    <= mapping_count_next;
                range_pending_reg    <= range_pending_next;
                pending_start_reg    <= pending_start_next;
                pending_writable_reg <= pending_writable_next;
                error_status_reg     <= error_status_next;
                res_valid_reg        <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload register: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
            res_data_reg <= res_data_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_block_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> position_reg == '0 && mapping_count_reg == '0
                           && error_status_reg == ST_OK && !range_pending_reg)
        else $error("block state not cleared after last word");

    a_map_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mapping_count_reg <= MAP_LIM)
        else $error("mapping count passed the limit");

    // A range is never left pending with an error stored or at a block start
    a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
        range_pending_reg |-> error_status_reg == ST_OK && position_reg != '0)
        else $error("range pending with error or at block start");

    a_skip_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.kind == KIND_SKIPPED
            |-> res_data_reg.status != ST_OK)
        else $error("skipped word without error status");

endmodule
`default_nettype wire

// ===== test/kernel_capability_descriptor_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_capability_descriptor_decoder_tb: self-checking bench for the decoder
// Drives blocks of capability descriptor words through the valid/ready input
// channel, decodes every accepted word in a bench-side model of the block
// state and compares each result word field by field, in order. A directed
// table covers each descriptor class and every error path. Random blocks
// follow, mostly well-formed with random content, some noisy, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module kernel_capability_descriptor_decoder_tb;
    import kcd_pkg::*;

    localparam int MAX_MAPS     = MAX_MAPPINGS_DEF;
    localparam int BLOCK_WORDS  = DESCRIPTOR_COUNT_DEF;
    localparam int RANDOM_WORDS = 16 * BLOCK_WORDS;
    localparam int IDLE_PERCENT = 27;

    // Prefix masks and patterns of the descriptor classes, checked in this order.
    localparam logic [31:0] MASK_INTERRUPT = 32'hF000_0000;
    localparam logic [31:0] PFX_INTERRUPT  = 32'hE000_0000;
    localparam logic [31:0] MASK_SYSCALL   = 32'hF800_0000;
    localparam logic [31:0] PFX_SYSCALL    = 32'hF000_0000;
    localparam logic [31:0] MASK_RELEASE   = 32'hFE00_0000;
    localparam logic [31:0] PFX_RELEASE    = 32'hFC00_0000;
    localparam logic [31:0] MASK_HANDLES   = 32'hFF00_0000;
    localparam logic [31:0] PFX_HANDLES    = 32'hFE00_0000;
    localparam logic [31:0] MASK_FLAGS     = 32'hFF80_0000;
    localparam logic [31:0] PFX_FLAGS      = 32'hFF00_0000;
    localparam logic [31:0] MASK_RANGE     = 32'hFFE0_0000;
    localparam logic [31:0] PFX_RANGE      = 32'hFF80_0000;
    localparam logic [31:0] MASK_PAGE      = 32'hFFF0_0000;
    localparam logic [31:0] PFX_PAGE       = 32'hFFE0_0000;
    localparam logic [31:0] WORD_PADDING   = 32'hFFFF_FFFF;

    typedef struct {
        logic [31:0] word;
        int          reps;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    kcd_desc_if   desc_ch ();
    kcd_result_if res_ch ();

    kernel_capability_descriptor_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .desc  (desc_ch),
        .res   (res_ch)
    );

    // Bench copy of the block state.
    logic [5:0]  blk_pos;
    logic [6:0]  map_count;
    bit          range_open;
    logic [19:0] open_first_page;
    bit          range_writable;
    status_t     sticky_err;

    result_t     pending_results[$];
    stim_row_t   plan[$];
    int          mismatch_count;
    int          results_seen;
    bit          steady;
    bit          noisy_block;
    bit          heavy_maps;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
    endtask

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    function automatic void clear_block();
        blk_pos         = '0;
        map_count       = '0;
        range_open      = 1'b0;
        open_first_page = '0;
        range_writable  = 1'b0;
        sticky_err      = ST_OK;
    endfunction

    // Latch the error as sticky and drop any open range.
    function automatic result_t raise_error(input status_t code);
        result_t r;
        r = '0;
        sticky_err = code;
        range_open = 1'b0;
        r.kind     = KIND_SKIPPED;
        r.status   = code;
        return r;
    endfunction

    // Decode one accepted word against the block state and advance the state.
    function automatic result_t decode_word(input logic [31:0] d);
        result_t r;
        bit      at_end;
        r = '0;
        at_end = (blk_pos >= BLOCK_WORDS - 1);

        if (sticky_err != ST_OK)
        begin
            r.kind   = KIND_SKIPPED;
            r.status = sticky_err;
        end
        else if (range_open)
        begin
            // Second word of a range: bit 20 picks static, the first word's bit 20 rw.
            range_open = 1'b0;
            if ((d & MASK_RANGE) != PFX_RANGE)
                r = raise_error(ST_CORRUPT);
            else
            begin
                r.kind      = KIND_MAPPING;
                r.slot      = map_count[5:0];
                r.map_start = open_first_page;
                r.map_end   = {1'b0, d[19:0]};
                if (d[20])
                    r.map_type = range_writable ? MAP_STATIC_RW : MAP_STATIC_RO;
                else
                    r.map_type = range_writable ? MAP_IO_RW : MAP_IO_RO;
                map_count = map_count + 7'd1;
            end
        end
        else if ((d & MASK_INTERRUPT) == PFX_INTERRUPT)
            r = raise_error(ST_UNSUPPORTED);
        else if ((d & MASK_SYSCALL) == PFX_SYSCALL)
        begin
            r.kind  = KIND_SYSCALL;
            r.slot  = {3'b000, d[26:24]};
            r.value = d[23:0];
        end
        else if ((d & MASK_RELEASE) == PFX_RELEASE)
        begin
            r.kind  = KIND_RELEASE;
            r.value = {8'h00, d[15:0]};
        end
        else if ((d & MASK_HANDLES) == PFX_HANDLES)
        begin
            r.kind  = KIND_HANDLES;
            r.value = {14'h0000, d[9:0]};
        end
        else if ((d & MASK_FLAGS) == PFX_FLAGS)
        begin
            r.kind  = KIND_FLAGS;
            r.value = {8'h00, d[15:0]};
        end
        else if ((d & MASK_RANGE) == PFX_RANGE)
        begin
            // Limit wins over a range cut off by the end of the block.
            if (map_count >= MAX_MAPS)
                r = raise_error(ST_LIMIT);
            else if (at_end)
                r = raise_error(ST_CORRUPT);
            else
            begin
                range_open      = 1'b1;
                open_first_page = d[19:0];
                range_writable  = d[20];
                r.kind          = KIND_RANGE;
                r.slot          = map_count[5:0];
                r.map_start     = d[19:0];
            end
        end
        else if ((d & MASK_PAGE) == PFX_PAGE)
        begin
            if (map_count >= MAX_MAPS)
                r = raise_error(ST_LIMIT);
            else
            begin
                r.kind      = KIND_MAPPING;
                r.slot      = map_count[5:0];
                r.map_start = d[19:0];
                r.map_end   = {1'b0, d[19:0]} + 21'd1;
                r.map_type  = d[20] ? MAP_IO_RW : MAP_IO_RO;
                map_count   = map_count + 7'd1;
            end
        end
        else if (d == WORD_PADDING)
            r.kind = KIND_PADDING;
        else
            r = raise_error(ST_CORRUPT);

        if (at_end)
        begin
            r.block_done = 1'b1;
            clear_block();
        end
        else
            blk_pos = blk_pos + 6'd1;
        return r;
    endfunction

    function automatic result_t want(input kind_t k, input status_t s, input logic [5:0] slot,
                                     input logic [23:0] v, input logic [19:0] ms,
                                     input logic [20:0] me, input map_type_t mt,
                                     input logic done);
        result_t r;
        r.kind       = k;
        r.status     = s;
        r.slot       = slot;
        r.value      = v;
        r.map_start  = ms;
        r.map_end    = me;
        r.map_type   = mt;
        r.block_done = done;
        return r;
    endfunction

    function automatic void add_row(input logic [31:0] word, input int reps, input bit typed,
                                    input result_t exp_word);
        stim_row_t row;
        row.word  = word;
        row.reps  = reps;
        row.typed = typed;
        row.want  = exp_word;
        plan.push_back(row);
    endfunction

    // Pick the next random word. Mostly well-formed: a range first word is
    // followed by its second word, and clean blocks rarely inject an error.
    function automatic logic [31:0] pick_word();
        int          roll;
        int          map_share;
        logic [31:0] r;
        roll      = $urandom_range(0, 99);
        r         = $urandom;
        map_share = heavy_maps ? 55 : 15;
        if (noisy_block && roll < 25)
            return r;
        if (range_open)
            return (roll < 92) ? {11'h7FC, r[20:0]} : r;
        if (!noisy_block && $urandom_range(0, 99) == 0)
            return r[31] ? {4'hE, r[27:0]} : {1'b0, r[30:0]};
        if (roll < 25 + map_share)
        begin
            // Keep clean blocks from opening a range on the last word, mostly.
            if (r[31] && (blk_pos != BLOCK_WORDS - 1 || noisy_block))
                return {11'h7FC, r[20:0]};
            return {12'hFFE, r[19:0]};
        end
        case (roll % 5)
            0: return {5'b11110, r[26:0]};
            1: return {7'b1111110, r[24:0]};
            2: return {8'hFE, r[23:0]};
            3: return {9'b111111110, r[22:0]};
            default: return WORD_PADDING;
        endcase
    endfunction

    // Present one word at the falling edge, hold it until accepted, then queue
    // its expected result. Returns at the falling edge after acceptance.
    task automatic send_word(input logic [31:0] word, input bit typed, input result_t exp_word);
        result_t predicted;
        while (idle_now())
        begin
            desc_ch.valid <= 1'b0;
            @(negedge clk);
        end
        desc_ch.valid      <= 1'b1;
        desc_ch.descriptor <= word;
        @(posedge clk);
        while (!desc_ch.ready)
            @(posedge clk);
        predicted = decode_word(word);
        pending_results.push_back(typed ? exp_word : predicted);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
    endtask

    task automatic check_result(input result_t got);
        result_t exp_word;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result %h with nothing expected", got));
            return;
        end
        exp_word = pending_results.pop_front();
        check_field("kind", 32'(got.kind), 32'(exp_word.kind));
        check_field("status", 32'(got.status), 32'(exp_word.status));
        check_field("slot", 32'(got.slot), 32'(exp_word.slot));
        check_field("value", 32'(got.value), 32'(exp_word.value));
        check_field("map_start", 32'(got.map_start), 32'(exp_word.map_start));
        check_field("map_end", 32'(got.map_end), 32'(exp_word.map_end));
        check_field("map_type", 32'(got.map_type), 32'(exp_word.map_type));
        check_field("block_done", 32'(got.block_done), 32'(exp_word.block_done));
    endtask

    // Result side: stall at random, sample at the rising edge.
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            res_ch.ready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            check_result(res_ch.data);
            results_seen++;
        end
    end

    initial
    begin
        result_t none;
        none               = '0;
        rst_n              = 1'b0;
        desc_ch.valid      = 1'b0;
        desc_ch.descriptor = '0;
        mismatch_count     = 0;
        results_seen       = 0;
        steady             = 1'b0;
        noisy_block        = 1'b0;
        heavy_maps         = 1'b0;
        clear_block();

        // Block 0: every good class, both range types, fill up to the mapping
        // limit with single pages, then hit the limit and skip the rest.
        add_row(WORD_PADDING, 1, 1,
                want(KIND_PADDING, ST_OK, 6'd0, 24'h0, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'hF7FF_FFFF, 1, 1,
                want(KIND_SYSCALL, ST_OK, 6'd7, 24'hFFFFFF, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'hF000_0000, 1, 1,
                want(KIND_SYSCALL, ST_OK, 6'd0, 24'h0, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'hFDFF_FFFF, 1, 1,
                want(KIND_RELEASE, ST_OK, 6'd0, 24'hFFFF, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'hFEFF_FFFF, 1, 1,
                want(KIND_HANDLES, ST_OK, 6'd0, 24'h3FF, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'hFF7F_FFFF, 1, 1,
                want(KIND_FLAGS, ST_OK, 6'd0, 24'hFFFF, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'hFF9F_FFFF, 1, 0, none);    // range, writable
        add_row(32'hFF90_0000, 1, 0, none);    // second word, static
        add_row(32'hFF81_2345, 1, 0, none);    // range, read-only
        add_row(32'hFF8A_BCDE, 1, 0, none);    // second word, io
        add_row(32'hFFEF_FFFF, 1, 1,
                want(KIND_MAPPING, ST_OK, 6'd2, 24'h0, 20'hFFFFF, 21'h100000, MAP_IO_RO, 1'b0));
        add_row(32'hFFE0_0000, 1, 1,
                want(KIND_MAPPING, ST_OK, 6'd3, 24'h0, 20'h0, 21'h1, MAP_IO_RO, 1'b0));
        add_row(32'hFFE5_A5A5, 4, 0, none);
        add_row(32'hFFE0_0001, 1, 1,
                want(KIND_SKIPPED, ST_LIMIT, 6'd0, 24'h0, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'h0000_0000, 11, 0, none);
        // Block 1: range whose second word carries the wrong prefix.
        add_row(32'hFF80_0000, 1, 0, none);
        add_row(32'hFF00_0000, 1, 1,
                want(KIND_SKIPPED, ST_CORRUPT, 6'd0, 24'h0, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(WORD_PADDING, 26, 0, none);
        // Block 2: interrupt descriptor is unsupported.
        add_row(32'hEFFF_FFFF, 1, 1,
                want(KIND_SKIPPED, ST_UNSUPPORTED, 6'd0, 24'h0, 20'h0, 21'h0, MAP_STATIC_RW,
                     1'b0));
        add_row(32'hF123_4567, 27, 0, none);
        // Block 3: one short of all ones is an unknown prefix.
        add_row(32'hFFFF_FFFE, 1, 1,
                want(KIND_SKIPPED, ST_CORRUPT, 6'd0, 24'h0, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'hFFF0_0000, 27, 0, none);
        // Block 4: range opened on the last word of the block.
        add_row(WORD_PADDING, 27, 0, none);
        add_row(32'hFF9F_FFFF, 1, 1,
                want(KIND_SKIPPED, ST_CORRUPT, 6'd0, 24'h0, 20'h0, 21'h0, MAP_STATIC_RW, 1'b1));
        // Block 5: range opened at the mapping limit.
        add_row(32'hFFE1_2345, 8, 0, none);
        add_row(32'hFF80_0000, 1, 1,
                want(KIND_SKIPPED, ST_LIMIT, 6'd0, 24'h0, 20'h0, 21'h0, MAP_STATIC_RW, 1'b0));
        add_row(32'hFF80_0000, 19, 0, none);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            repeat (plan[i].reps)
                send_word(plan[i].word, plan[i].typed, plan[i].want);
        end

        // Random blocks; the directed table ends on a block boundary.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            steady = (n >= 280 && n < 420);
            if (blk_pos == 0)
            begin
                noisy_block = ($urandom_range(0, 3) == 0);
                heavy_maps  = ($urandom_range(0, 1) == 1);
            end
            send_word(pick_word(), 1'b0, none);
        end
        steady         = 1'b0;
        desc_ch.valid <= 1'b0;

        // Drain, then leave time for a stray extra result to show up.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
